[rtl/core/pn3_pkg.sv]
package pn3_pkg;

  localparam int GRID_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W     = 24;
  localparam int OUT_W       = 19;
  localparam int TBL_DEPTH   = 256;
  localparam int TBL_AW      = 8;
  localparam int TBL_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 32;
  localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  // Lattice cells are already reduced modulo the grid size; tbl_red is the
  // table value reduced the same way, tbl_raw the value as written.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] tbl_index;
    logic [7:0] tbl_raw;
    logic [7:0] tbl_red;
    logic [7:0] cx;
    logic [7:0] cx1;
    logic [7:0] cy;
    logic [7:0] cy1;
    logic [7:0] cz;
    logic [7:0] cz1;
  } item_t;

endpackage

[rtl/core/pn3_ram.sv]
module pn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[rtl/core/pn3_fifo.sv]
module pn3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

[rtl/core/pn3_front.sv]
module pn3_front #(
  parameter int GRID_SIZE = pn3_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         kind,
  input  logic [7:0]                   table_index,
  input  logic [7:0]                   table_value,
  input  logic [pn3_pkg::COORD_W-1:0]  x_coord,
  input  logic [pn3_pkg::COORD_W-1:0]  y_coord,
  input  logic [pn3_pkg::COORD_W-1:0]  z_coord,
  output logic                         push,
  output pn3_pkg::item_t               item,
  output logic [3*FRAC_BITS-1:0]       frac,
  output logic [1:0]                   busy
);

  localparam int IW    = pn3_pkg::COORD_W - FRAC_BITS;
  localparam int IWE   = (IW < 1) ? 1 : IW;
  localparam int RMW   = IWE + 10;
  localparam logic [IWE-1:0] RECIP = IWE'((2 ** IWE) / GRID_SIZE);
  localparam logic [9:0] G10 = 10'(GRID_SIZE);

  logic [7:0] red_tbl [pn3_pkg::TBL_DEPTH];

  for (genvar i = 0; i < pn3_pkg::TBL_DEPTH; i++) begin : g_red
    assign red_tbl[i] = 8'(i % GRID_SIZE);
  end

  logic [pn3_pkg::COORD_W-1:0] coord [3];
  logic [IWE-1:0]              ip_c [3];
  logic [2*IWE-1:0]            qp_c [3];

  logic                  s1_vld_r;
  pn3_pkg::kind_t        s1_kind_r;
  logic [7:0]            s1_tidx_r;
  logic [7:0]            s1_traw_r;
  logic [7:0]            s1_tred_r;
  logic [IWE-1:0]        s1_ip_r [3];
  logic [IWE-1:0]        s1_q_r [3];
  logic [FRAC_BITS-1:0]  s1_frac_r [3];

  logic                  s2_vld_r;
  pn3_pkg::kind_t        s2_kind_r;
  logic [7:0]            s2_tidx_r;
  logic [7:0]            s2_traw_r;
  logic [7:0]            s2_tred_r;
  logic [9:0]            s2_rem_r [3];
  logic [FRAC_BITS-1:0]  s2_frac_r [3];

  logic [7:0] cidx [3];
  logic [7:0] cidx1 [3];

  assign coord[0] = x_coord;
  assign coord[1] = y_coord;
  assign coord[2] = z_coord;

  // The integer part is reduced modulo the grid size by a reciprocal
  // estimate, a multiply back and one final correction.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ip_c[c] = IWE'(coord[c] >> FRAC_BITS);
      qp_c[c] = (2*IWE)'(ip_c[c]) * (2*IWE)'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= pn3_pkg::kind_t'(kind);
    s1_tidx_r <= table_index;
    s1_traw_r <= table_value;
    s1_tred_r <= red_tbl[table_value];
    s2_kind_r <= s1_kind_r;
    s2_tidx_r <= s1_tidx_r;
    s2_traw_r <= s1_traw_r;
    s2_tred_r <= s1_tred_r;
    for (int c = 0; c < 3; c++) begin
      s1_ip_r[c]   <= ip_c[c];
      s1_q_r[c]    <= qp_c[c][2*IWE-1:IWE];
      s1_frac_r[c] <= coord[c][FRAC_BITS-1:0];
      s2_rem_r[c]  <= 10'(RMW'(s1_ip_r[c]) - RMW'(s1_q_r[c]) * RMW'(GRID_SIZE));
      s2_frac_r[c] <= s1_frac_r[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cidx[c]  = (s2_rem_r[c] >= G10) ? 8'(s2_rem_r[c] - G10) : 8'(s2_rem_r[c]);
      cidx1[c] = (cidx[c] == 8'(GRID_SIZE - 1)) ? 8'd0 : cidx[c] + 8'd1;
    end
  end

  always_comb begin
    item.kind      = s2_kind_r;
    item.tbl_index = s2_tidx_r;
    item.tbl_raw   = s2_traw_r;
    item.tbl_red   = s2_tred_r;
    item.cx        = cidx[0];
    item.cx1       = cidx1[0];
    item.cy        = cidx[1];
    item.cy1       = cidx1[1];
    item.cz        = cidx[2];
    item.cz1       = cidx1[2];
    frac           = {s2_frac_r[2], s2_frac_r[1], s2_frac_r[0]};
  end

  assign push = s2_vld_r;
  assign busy = {1'b0, s1_vld_r} + {1'b0, s2_vld_r};

endmodule

[rtl/core/pn3_back.sv]
module pn3_back #(
  parameter int GRID_SIZE = pn3_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  pn3_pkg::item_t                q_item,
  input  logic [3*FRAC_BITS-1:0]        q_frac,
  output logic                          q_pop,
  input  logic [pn3_pkg::OUT_CW-1:0]    out_count,
  output logic                          res_push,
  output logic [pn3_pkg::OUT_W-1:0]     res_value
);

  localparam int F   = FRAC_BITS;
  localparam int DW  = F + 3;
  localparam int BW  = F + 4;
  localparam int MW  = F + 3;
  localparam int FW  = F + 1;
  localparam int RSW = F + 4;
  localparam int RW  = F + 5;
  localparam int NR  = 7;
  localparam int SW  = ((DW > pn3_pkg::OUT_W) ? DW : pn3_pkg::OUT_W) + 1;
  localparam int OW  = pn3_pkg::OUT_W;
  localparam int CW  = pn3_pkg::OUT_CW;

  localparam logic [8:0]             G9      = 9'(GRID_SIZE);
  localparam logic [RW-1:0]          TEN_ONE = RW'(10) << F;
  localparam logic signed [DW-1:0]   ONE_D   = DW'(1) << F;
  localparam logic signed [SW-1:0]   SAT_HI  = SW'((1 << (OW - 1)) - 1);
  localparam logic signed [SW-1:0]   SAT_LO  = -SAT_HI - SW'(1);

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic                 neg;
    logic [MW-1:0]        mag;
  } lstep_t;

  function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= G9) begin
      s = s - G9;
    end
    return s[7:0];
  endfunction

  function automatic lstep_t lerp_diff(input logic signed [DW-1:0] a,
                                       input logic signed [DW-1:0] b);
    lstep_t st;
    logic signed [BW-1:0] d;
    d      = BW'(b) - BW'(a);
    st.a   = a;
    st.neg = d[BW-1];
    st.mag = d[BW-1] ? MW'(-d) : MW'(d);
    return st;
  endfunction

  function automatic logic [MW-1:0] lerp_mul(input logic [MW-1:0] mag,
                                             input logic [FW-1:0] s);
    logic [MW+FW-1:0] pr;
    pr = (MW+FW)'(mag) * (MW+FW)'(s);
    return pr[F+MW-1:F];
  endfunction

  function automatic logic signed [DW-1:0] lerp_sum(input logic signed [DW-1:0] a,
                                                    input logic neg,
                                                    input logic [MW-1:0] p);
    logic signed [BW-1:0] s;
    s = neg ? (BW'(a) - $signed(BW'(p))) : (BW'(a) + $signed(BW'(p)));
    return DW'(s);
  endfunction

  logic           issue;
  logic           issue_eval;
  logic           issue_load;
  logic           room;
  logic [CW:0]    used;
  logic [CW-1:0]  inflight_r;
  logic [13:1]    vld_r;

  assign used = {1'b0, inflight_r} + {1'b0, out_count};
  assign room = (used < (CW+1)'(pn3_pkg::OUT_DEPTH));

  // A load waits while an evaluation issued in the previous cycle still has
  // its last table read ahead of it.
  always_comb begin
    issue = 1'b0;
    if (!q_empty) begin
      unique case (q_item.kind)
        pn3_pkg::KIND_EVAL: issue = room;
        pn3_pkg::KIND_LOAD: issue = !vld_r[1];
      endcase
    end
  end

  assign issue_eval = issue && (q_item.kind == pn3_pkg::KIND_EVAL);
  assign issue_load = issue && (q_item.kind == pn3_pkg::KIND_LOAD);
  assign q_pop      = issue;
  assign res_push   = vld_r[13];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      inflight_r <= '0;
    end else begin
      vld_r      <= {vld_r[12:1], issue_eval};
      inflight_r <= inflight_r + CW'(issue_eval) - CW'(res_push);
    end
  end

  logic [pn3_pkg::TBL_AW-1:0] ra_a [NR];
  logic [pn3_pkg::TBL_AW-1:0] ra_b [NR];
  logic [pn3_pkg::TBL_W-1:0]  rd_a [NR];
  logic [pn3_pkg::TBL_W-1:0]  rd_b [NR];

  for (genvar i = 0; i < NR; i++) begin : g_tbl
    pn3_ram #(
      .WIDTH (pn3_pkg::TBL_W),
      .DEPTH (pn3_pkg::TBL_DEPTH)
    ) u_ram (
      .clk       (clk),
      .wr_en     (issue_load),
      .wr_addr   (q_item.tbl_index),
      .wr_data   ({q_item.tbl_red, q_item.tbl_raw}),
      .rd_addr_a (ra_a[i]),
      .rd_addr_b (ra_b[i]),
      .rd_data_a (rd_a[i]),
      .rd_data_b (rd_b[i])
    );
  end

  logic [7:0]           p1_cy_r, p1_cy1_r, p1_cz_r, p1_cz1_r;
  logic [F-1:0]         p1_frac_r [3];
  logic [7:0]           p2_cz_r, p2_cz1_r;
  logic [F-1:0]         p2_frac_r [3];
  logic [F-1:0]         p2_t2_r [3];
  logic [F-1:0]         p3_frac_r [3];
  logic [F-1:0]         p3_t3_r [3];
  logic [RSW-1:0]       p3_r_r [3];
  logic signed [DW-1:0] p4_dot_r [8];
  logic [FW-1:0]        fd_r [4:11][3];

  lstep_t               p5_s_r [4];
  lstep_t               p6_s_r [4];
  logic [MW-1:0]        p6_p_r [4];
  logic signed [DW-1:0] p7_v_r [4];
  lstep_t               p8_s_r [2];
  lstep_t               p9_s_r [2];
  logic [MW-1:0]        p9_p_r [2];
  logic signed [DW-1:0] p10_v_r [2];
  lstep_t               p11_s_r;
  lstep_t               p12_s_r;
  logic [MW-1:0]        p12_p_r;
  logic signed [DW-1:0] p13_v_r;

  logic [7:0]           addr2 [4];
  logic [7:0]           addr3 [8];
  logic [2:0]           grad [8];
  logic [F-1:0]         t2_c [3];
  logic [F-1:0]         t3_c [3];
  logic [RSW-1:0]       r_c [3];
  logic [FW-1:0]        fade_c [3];
  logic signed [DW-1:0] dot_c [8];

  assign ra_a[0] = q_item.cx;
  assign ra_b[0] = q_item.cx1;
  assign ra_a[1] = addr2[0];
  assign ra_b[1] = addr2[1];
  assign ra_a[2] = addr2[2];
  assign ra_b[2] = addr2[3];

  for (genvar i = 0; i < 4; i++) begin : g_l3
    assign ra_a[3+i]   = addr3[2*i];
    assign ra_b[3+i]   = addr3[2*i+1];
    assign grad[2*i]   = rd_a[3+i][2:0];
    assign grad[2*i+1] = rd_b[3+i][2:0];
  end

  always_comb begin
    logic [7:0] hx;
    logic [7:0] h2;
    for (int j = 0; j < 4; j++) begin
      hx       = j[0] ? rd_b[0][15:8] : rd_a[0][15:8];
      addr2[j] = mod_add(hx, j[1] ? p1_cy1_r : p1_cy_r);
    end
    for (int k = 0; k < 8; k++) begin
      case (k % 4)
        0:       h2 = rd_a[1][15:8];
        1:       h2 = rd_b[1][15:8];
        2:       h2 = rd_a[2][15:8];
        default: h2 = rd_b[2][15:8];
      endcase
      addr3[k] = mod_add(h2, k[2] ? p2_cz1_r : p2_cz_r);
    end
  end

  always_comb begin
    logic [2*F-1:0]   sq;
    logic [2*F-1:0]   cu;
    logic [RW-1:0]    rr;
    logic [F+RSW-1:0] fp;
    for (int c = 0; c < 3; c++) begin
      sq        = (2*F)'(p1_frac_r[c]) * (2*F)'(p1_frac_r[c]);
      t2_c[c]   = sq[2*F-1:F];
      cu        = (2*F)'(p2_t2_r[c]) * (2*F)'(p2_frac_r[c]);
      t3_c[c]   = cu[2*F-1:F];
      rr        = RW'(p2_t2_r[c]) * RW'(6) + TEN_ONE - RW'(p2_frac_r[c]) * RW'(15);
      r_c[c]    = rr[RSW-1:0];
      fp        = (F+RSW)'(p3_t3_r[c]) * (F+RSW)'(p3_r_r[c]);
      fade_c[c] = fp[2*F:F];
    end
  end

  always_comb begin
    logic signed [DW-1:0] ox, oy, oz;
    for (int k = 0; k < 8; k++) begin
      ox = $signed(DW'(p3_frac_r[0])) - (k[0] ? ONE_D : DW'(0));
      oy = $signed(DW'(p3_frac_r[1])) - (k[1] ? ONE_D : DW'(0));
      oz = $signed(DW'(p3_frac_r[2])) - (k[2] ? ONE_D : DW'(0));
      dot_c[k] = ((grad[k][0] ^ grad[k][1]) ? -ox : ox)
               + (grad[k][1] ? -oy : oy)
               + (grad[k][2] ? -oz : oz);
    end
  end

  always_ff @(posedge clk) begin
    p1_cy_r  <= q_item.cy;
    p1_cy1_r <= q_item.cy1;
    p1_cz_r  <= q_item.cz;
    p1_cz1_r <= q_item.cz1;
    p2_cz_r  <= p1_cz_r;
    p2_cz1_r <= p1_cz1_r;
    for (int c = 0; c < 3; c++) begin
      p1_frac_r[c] <= q_frac[c*F +: F];
      p2_frac_r[c] <= p1_frac_r[c];
      p2_t2_r[c]   <= t2_c[c];
      p3_frac_r[c] <= p2_frac_r[c];
      p3_t3_r[c]   <= t3_c[c];
      p3_r_r[c]    <= r_c[c];
      fd_r[4][c]   <= fade_c[c];
    end
    for (int s = 5; s <= 11; s++) begin
      fd_r[s] <= fd_r[s-1];
    end
    for (int k = 0; k < 8; k++) begin
      p4_dot_r[k] <= dot_c[k];
    end
    for (int i = 0; i < 4; i++) begin
      p5_s_r[i] <= lerp_diff(p4_dot_r[2*i], p4_dot_r[2*i+1]);
      p6_s_r[i] <= p5_s_r[i];
      p6_p_r[i] <= lerp_mul(p5_s_r[i].mag, fd_r[5][0]);
      p7_v_r[i] <= lerp_sum(p6_s_r[i].a, p6_s_r[i].neg, p6_p_r[i]);
    end
    for (int i = 0; i < 2; i++) begin
      p8_s_r[i]  <= lerp_diff(p7_v_r[2*i], p7_v_r[2*i+1]);
      p9_s_r[i]  <= p8_s_r[i];
      p9_p_r[i]  <= lerp_mul(p8_s_r[i].mag, fd_r[8][1]);
      p10_v_r[i] <= lerp_sum(p9_s_r[i].a, p9_s_r[i].neg, p9_p_r[i]);
    end
    p11_s_r <= lerp_diff(p10_v_r[0], p10_v_r[1]);
    p12_s_r <= p11_s_r;
    p12_p_r <= lerp_mul(p11_s_r.mag, fd_r[11][2]);
    p13_v_r <= lerp_sum(p12_s_r.a, p12_s_r.neg, p12_p_r);
  end

  always_comb begin
    logic signed [SW-1:0] res_ext;
    res_ext = SW'(p13_v_r);
    if (res_ext > SAT_HI) begin
      res_value = OW'(SAT_HI);
    end else if (res_ext < SAT_LO) begin
      res_value = OW'(SAT_LO);
    end else begin
      res_value = OW'(res_ext);
    end
  end

endmodule

[rtl/core/perlin_noise_3d_top.sv]
// Throughput: one item per cycle when no queue ahead of it is backed up; a
// load item that directly follows an evaluate item waits for the last table
// lookup of that item.
// Reset: synchronous, active low; it empties both queues and the pipeline.
// The permutation table is not cleared and holds no value until loaded.
module perlin_noise_3d_top #(
  parameter int GRID_SIZE = pn3_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_kind,
  input  logic [7:0]                        in_table_index,
  input  logic [7:0]                        in_table_value,
  input  logic [pn3_pkg::COORD_W-1:0]       in_x_coord,
  input  logic [pn3_pkg::COORD_W-1:0]       in_y_coord,
  input  logic [pn3_pkg::COORD_W-1:0]       in_z_coord,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [pn3_pkg::OUT_W-1:0]  out_noise_value
);

  localparam int QW = $bits(pn3_pkg::item_t) + 3 * FRAC_BITS;

  logic                          accept;
  logic                          f_push;
  pn3_pkg::item_t                f_item;
  logic [3*FRAC_BITS-1:0]        f_frac;
  logic [1:0]                    f_busy;
  logic [QW-1:0]                 q_dout;
  logic                          q_empty;
  logic [pn3_pkg::QUEUE_CW-1:0]  q_count;
  logic                          q_pop;
  logic [pn3_pkg::QUEUE_CW:0]    q_used;
  logic [pn3_pkg::OUT_CW-1:0]    o_count;
  logic                          res_push;
  logic [pn3_pkg::OUT_W-1:0]     res_value;
  logic [pn3_pkg::OUT_W-1:0]     o_dout;

  assign q_used  = (pn3_pkg::QUEUE_CW+1)'(q_count) + (pn3_pkg::QUEUE_CW+1)'(f_busy);
  assign in_full = (q_used >= (pn3_pkg::QUEUE_CW+1)'(pn3_pkg::QUEUE_DEPTH));
  assign accept  = in_push && !in_full;

  pn3_front #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .kind        (in_kind),
    .table_index (in_table_index),
    .table_value (in_table_value),
    .x_coord     (in_x_coord),
    .y_coord     (in_y_coord),
    .z_coord     (in_z_coord),
    .push        (f_push),
    .item        (f_item),
    .frac        (f_frac),
    .busy        (f_busy)
  );

  pn3_fifo #(
    .WIDTH (QW),
    .DEPTH (pn3_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   ({f_item, f_frac}),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  pn3_back #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_dout[QW-1:3*FRAC_BITS]),
    .q_frac    (q_dout[3*FRAC_BITS-1:0]),
    .q_pop     (q_pop),
    .out_count (o_count),
    .res_push  (res_push),
    .res_value (res_value)
  );

  pn3_fifo #(
    .WIDTH (pn3_pkg::OUT_W),
    .DEPTH (pn3_pkg::OUT_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_value),
    .pop   (out_pop && !out_empty),
    .dout  (o_dout),
    .empty (out_empty),
    .count (o_count)
  );

  assign out_noise_value = $signed(o_dout);

endmodule

[rtl/core/pn3_checker.sv]
module pn3_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_push,
  input logic                              in_full,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic signed [pn3_pkg::OUT_W-1:0]  out_noise_value
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible right after reset");

  // Reset leaves the input side open.
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  // Back pressure on the input can only build up through an accepted item.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input became full without an accepted item");

  // A waiting result is neither lost nor changed until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_noise_value)))
    else $error("waiting result changed or vanished");

endmodule

bind perlin_noise_3d_top pn3_checker u_pn3_checker (.*);

[verif/tb_perlin_noise_3d_top.sv]
`timescale 1ns / 100ps

module tb_perlin_noise_3d_top;

  localparam int GRID = pn3_pkg::GRID_SIZE_DEF;
  localparam int FB = pn3_pkg::FRAC_BITS_DEF;
  localparam int RAND_ITEMS = 483;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic signed [18:0] NOISE_MAX = 19'sd262143;
  localparam logic signed [18:0] NOISE_MIN = -19'sd262144;

  typedef struct {
    pn3_pkg::kind_t kind;
    logic [7:0]  index;
    logic [7:0]  value;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    bit          has_fixed;
    logic signed [18:0] fixed_noise;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic in_kind;
  logic [7:0] in_table_index;
  logic [7:0] in_table_value;
  logic [23:0] in_x_coord;
  logic [23:0] in_y_coord;
  logic [23:0] in_z_coord;
  logic out_empty;
  logic out_pop;
  logic signed [18:0] out_noise_value;

  logic [7:0] perm_copy [0:255];
  logic signed [18:0] expected_noise [$];
  int mismatches;
  int noise_checked;
  int items_sent;
  int loads_sent;
  int idle_cycles;
  bit watchdog_hit;
  bit stall_mode;

  perlin_noise_3d_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_kind(in_kind), .in_table_index(in_table_index),
    .in_table_value(in_table_value), .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord), .in_z_coord(in_z_coord),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_noise_value(out_noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fade_of(longint t);
    longint t2, r, t3;
    t2 = (t * t) >>> FB;
    r = 6 * t2 + 10 * (64'sd1 << FB) - 15 * t;
    t3 = (t2 * t) >>> FB;
    return (t3 * r) >>> FB;
  endfunction

  function automatic longint mix(longint a, longint b, longint s);
    longint d, p;
    d = b - a;
    p = ((d < 0 ? -d : d) * s) >>> FB;
    return a + (d < 0 ? -p : p);
  endfunction

  function automatic logic signed [18:0] noise_at(logic [23:0] x, logic [23:0] y,
                                                  logic [23:0] z);
    int ipart [3];
    longint frac [3];
    longint dots [8];
    longint lx [4];
    longint ly [2];
    longint res, ox, oy, oz, one;
    int h, g;
    logic [23:0] c [3];
    c[0] = x;
    c[1] = y;
    c[2] = z;
    one = 64'sd1 << FB;
    for (int k = 0; k < 3; k++) begin
      ipart[k] = (c[k] >> FB) % GRID;
      frac[k] = c[k] & (one - 1);
    end
    for (int k = 0; k < 8; k++) begin
      h = perm_copy[(ipart[0] + (k & 1)) % GRID];
      h = perm_copy[(h + ipart[1] + ((k >> 1) & 1)) % GRID];
      h = perm_copy[(h + ipart[2] + ((k >> 2) & 1)) % GRID];
      g = h & 7;
      ox = frac[0] - ((k & 1) ? one : 0);
      oy = frac[1] - (((k >> 1) & 1) ? one : 0);
      oz = frac[2] - (((k >> 2) & 1) ? one : 0);
      dots[k] = ((((g + 1) >> 1) & 1) ? -ox : ox) + (((g >> 1) & 1) ? -oy : oy)
                + (((g >> 2) & 1) ? -oz : oz);
    end
    for (int k = 0; k < 4; k++) lx[k] = mix(dots[2 * k], dots[2 * k + 1], fade_of(frac[0]));
    for (int k = 0; k < 2; k++) ly[k] = mix(lx[2 * k], lx[2 * k + 1], fade_of(frac[1]));
    res = mix(ly[0], ly[1], fade_of(frac[2]));
    if (res > NOISE_MAX) res = NOISE_MAX;
    if (res < NOISE_MIN) res = NOISE_MIN;
    return res[18:0];
  endfunction

  // Drives one item and holds it until the block takes it.
  task automatic send_item(pn3_pkg::kind_t kind, logic [7:0] index, logic [7:0] value,
                           logic [23:0] x, logic [23:0] y, logic [23:0] z,
                           bit has_fixed, logic signed [18:0] fixed_noise);
    in_push <= 1'b1;
    in_kind <= kind;
    in_table_index <= index;
    in_table_value <= value;
    in_x_coord <= x;
    in_y_coord <= y;
    in_z_coord <= z;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (kind == pn3_pkg::KIND_LOAD) begin
      perm_copy[index] = value;
      loads_sent++;
    end else begin
      expected_noise.push_back(has_fixed ? fixed_noise : noise_at(x, y, z));
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'hFFFFFF;
      1: return {8'($urandom_range(0, 255)), 16'h0000};
      2: return {8'($urandom_range(0, 255)), 16'hFFFF};
      default: return 24'($urandom());
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected noise result %0d with nothing pending", out_noise_value);
      end else begin
        if (out_noise_value !== expected_noise[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Noise mismatch: expected %0d, got %0d", expected_noise[0],
                     out_noise_value);
        end
        void'(expected_noise.pop_front());
        noise_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      out_pop <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT && !watchdog_hit) begin
      watchdog_hit = 1'b1;
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    int burst;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_kind = pn3_pkg::KIND_LOAD;
    in_table_index = '0;
    in_table_value = '0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_z_coord = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zero table, then coordinate extremes and mid-cell points, with table loads between.
    for (int i = 0; i < 256; i++)
      send_item(pn3_pkg::KIND_LOAD, 8'(i), 8'h00, 24'($urandom()), 24'($urandom()),
                24'($urandom()), 1'b0, '0);
    rows = '{
      '{pn3_pkg::KIND_EVAL, 8'hFF, 8'hFF, 24'h000000, 24'h000000, 24'h000000, 1'b1, 19'sd0},
      '{pn3_pkg::KIND_EVAL, 8'h00, 8'h00, 24'h010000, 24'h020000, 24'hFF0000, 1'b1, 19'sd0},
      '{pn3_pkg::KIND_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{pn3_pkg::KIND_EVAL, 8'h00, 8'h00, 24'h008000, 24'h008000, 24'h008000, 1'b0, '0},
      '{pn3_pkg::KIND_EVAL, 8'h00, 8'h00, 24'h00FFFF, 24'h000000, 24'h00FFFF, 1'b0, '0},
      '{pn3_pkg::KIND_LOAD, 8'h00, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{pn3_pkg::KIND_LOAD, 8'hFF, 8'h07, 24'h000000, 24'h000000, 24'h000000, 1'b0, '0},
      '{pn3_pkg::KIND_LOAD, 8'h01, 8'h05, 24'h000000, 24'h000000, 24'h000000, 1'b0, '0},
      '{pn3_pkg::KIND_EVAL, 8'hAA, 8'h55, 24'hFF8000, 24'h004000, 24'h00C000, 1'b0, '0},
      '{pn3_pkg::KIND_EVAL, 8'h55, 8'hAA, 24'h001234, 24'hFFFFFF, 24'h000001, 1'b0, '0},
      '{pn3_pkg::KIND_EVAL, 8'h00, 8'h00, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b0, '0}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.kind, row.index, row.value, row.x, row.y, row.z, row.has_fixed,
                row.fixed_noise);
    end

    // Pause until all results have drained.
    in_push <= 1'b0;
    while (expected_noise.size() != 0) @(negedge clk);

    while (items_sent < 256 + rows.size() + RAND_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(pn3_pkg::KIND_LOAD, 8'($urandom()), 8'($urandom()), 24'($urandom()),
                    24'($urandom()), 24'($urandom()), 1'b0, '0);
        else
          send_item(pn3_pkg::KIND_EVAL, 8'($urandom()), 8'($urandom()), rand_coord(),
                    rand_coord(), rand_coord(), 1'b0, '0);
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_push <= 1'b0;

    while (expected_noise.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d items (%0d table loads), checked %0d noise values.",
             items_sent, loads_sent, noise_checked);
    if (mismatches == 0 && expected_noise.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("Mismatch count: %0d", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pn3_pkg.sv
rtl/core/pn3_ram.sv
rtl/core/pn3_fifo.sv
rtl/core/pn3_front.sv
rtl/core/pn3_back.sv
rtl/core/perlin_noise_3d_top.sv
rtl/core/pn3_checker.sv
verif/tb_perlin_noise_3d_top.sv
